>>> design/rgbclux_pkg.sv
// rgbclux_pkg: payload structs, sensor weights and color matrix for the rgbc conversion core
// no dependencies; imported by rgbc_to_lux_and_cct_core
`timescale 1ns / 1ps
`default_nettype none

package rgbclux_pkg;

   typedef struct packed {
      logic [15:0] clear_count;
      logic [15:0] red_count;
      logic [15:0] green_count;
      logic [15:0] blue_count;
   } rgbc_req_type;

   typedef struct packed {
      logic [15:0] lux_estimate;
      logic [15:0] colour_temp_kelvin;
      logic        sum_was_zero;
      logic        temp_saturated;
   } rgbc_rsp_type;

   // values that ride along the pipeline beside the arithmetic
   typedef struct packed {
      logic [15:0] lux;
      logic        zero;
      logic        sat;
      logic        pinned;
      logic [15:0] ftemp;
   } side_type;

   // lux weights, 16 fraction bits
   localparam int LUX_WC = 1704;
   localparam int LUX_WR = -5636;
   localparam int LUX_WG = 11600;
   localparam int LUX_WB = -3736;

   // rgb to xyz, 16 fraction bits
   localparam int M_XR = -9360;
   localparam int M_XG = 101531;
   localparam int M_XB = -62679;
   localparam int M_YR = -21277;
   localparam int M_YG = 103440;
   localparam int M_YB = -47966;
   localparam int M_ZR = -44697;
   localparam int M_ZG = 50511;
   localparam int M_ZB = 36918;

   localparam int XYZ_W    = 36;
   localparam int CUBIC_K1 = 449;
   localparam int TEMP_MAX = 65535;

endpackage

`default_nettype wire

>>> design/rgbc_to_lux_and_cct_core.sv
// rgbc_to_lux_and_cct_core: pipelined lux estimate and mccamy color temperature
// depends on rgbclux_pkg for payload structs and fixed coefficients
// throughput: one item per cycle while req_stall is low; the depth comes
//   from the two restoring dividers (one quotient bit per stage) and the two
//   split cubic multipliers
// a full output skid stage holds req_stall high until the held result drains
// reset (synchronous, active high) clears the stage valid bits and output valids
`timescale 1ns / 1ps
`default_nettype none

module rgbc_to_lux_and_cct_core
   import rgbclux_pkg::*;
#(
   parameter int FRAC_BITS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rgbc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rgbc_rsp_type rsp_data
);

   localparam int F = FRAC_BITS;
   localparam longint ONE  = longint'(1) << F;
   localparam longint HALF = ONE / 2;
   localparam longint CX_Q = (332 * ONE + 500) / 1000;
   localparam longint CY_Q = (1858 * ONE + 5000) / 10000;
   localparam longint K2_Q = 3525 * ONE;
   localparam longint K3_Q = (68233 * ONE + 5) / 10;
   localparam longint K4_Q = (552033 * ONE + 50) / 100;

   localparam int XW   = XYZ_W;
   localparam int DXW  = 39;
   localparam int NXS  = F + 3;
   localparam int QXW  = F + 3;
   localparam int CW   = F + 3;
   localparam int NW   = F + 4;
   localparam int DNW  = F + 10;
   localparam int NNS  = F + 7;
   localparam int QNW  = F + 7;
   localparam int NCW  = F + 6;
   localparam int NRW  = F + 4;
   localparam int NMW  = F + 3;
   localparam int TW   = F + 22;
   localparam int AW   = F + 21;
   localparam int AHW  = AW - 16;
   localparam int PLW  = 16 + NMW;
   localparam int PHW  = AHW + NMW;
   localparam int PW   = AW + NMW;
   localparam int DEPTH = NXS + NNS + 16;

   localparam logic [QXW-1:0] CH_LIM = QXW'(1) << (F + 1);
   localparam logic [QNW-1:0] N_LIM  = QNW'(1) << (F + 5);

   typedef struct packed {
      logic [DXW-1:0] xr;
      logic [DXW-1:0] yr;
      logic [DXW-1:0] e;
      logic [QXW-1:0] xq;
      logic [QXW-1:0] yq;
      logic           xneg;
      logic           yneg;
      logic           xovf;
      logic           yovf;
      side_type       side;
   } xdiv_type;

   typedef struct packed {
      logic [DNW-1:0] r;
      logic [DNW-1:0] e;
      logic [QNW-1:0] q;
      logic           neg;
      logic           ovf;
      side_type       side;
   } ndiv_type;

   typedef struct packed {
      logic signed [TW-1:0]  t;
      logic signed [NRW-1:0] n;
      side_type              side;
   } mul_type;

   typedef struct packed {
      logic [AW-1:0]         am;
      logic [NMW-1:0]        nm;
      logic                  neg;
      logic signed [NRW-1:0] n;
      side_type              side;
   } p0_type;

   typedef struct packed {
      logic [AHW-1:0]        ah;
      logic [NMW-1:0]        nm;
      logic [PLW-1:0]        pl;
      logic                  neg;
      logic signed [NRW-1:0] n;
      side_type              side;
   } p1_type;

   typedef struct packed {
      logic [PHW-1:0]        ph;
      logic [PLW-1:0]        pl;
      logic                  neg;
      logic signed [NRW-1:0] n;
      side_type              side;
   } p2_type;

   // rounded quotient magnitude to clamped chromaticity, sat flag on top
   function automatic logic [CW:0] clamp_xy(input logic [QXW-1:0] q, input logic neg,
                                            input logic ovf);
      logic [QXW-1:0]       mag;
      logic                 sat;
      logic signed [CW-1:0] v;
      mag = (q >> 1) + QXW'(q[0]);
      sat = 1'b0;
      if (!neg && (ovf || mag >= CH_LIM)) begin
         v   = CW'(2 * ONE - 1);
         sat = 1'b1;
      end else if (neg && (ovf || mag > CH_LIM)) begin
         v   = CW'(-2 * ONE);
         sat = 1'b1;
      end else begin
         v = neg ? -$signed(CW'(mag)) : $signed(CW'(mag));
      end
      return {sat, v};
   endfunction

   function automatic logic [NCW:0] clamp_n(input logic [QNW-1:0] q, input logic neg,
                                            input logic ovf);
      logic [QNW-1:0]        mag;
      logic                  sat;
      logic signed [NCW-1:0] v;
      mag = (q >> 1) + QNW'(q[0]);
      sat = 1'b0;
      if (!neg && (ovf || mag >= N_LIM)) begin
         v   = NCW'(32 * ONE - 1);
         sat = 1'b1;
      end else if (neg && (ovf || mag > N_LIM)) begin
         v   = NCW'(-32 * ONE);
         sat = 1'b1;
      end else begin
         v = neg ? -$signed(NCW'(mag)) : $signed(NCW'(mag));
      end
      return {sat, v};
   endfunction

   logic [DEPTH-1:0] vld_ff;
   logic             adv;

   rgbc_req_type          s1_ff;
   logic signed [XW-1:0]  s2_x_ff, s2_y_ff, s2_z_ff;
   logic signed [31:0]    s2_acc_ff;
   logic signed [XW-1:0]  s2_x_in, s2_y_in, s2_z_in;
   logic signed [31:0]    s2_acc_in;
   logic signed [XW-1:0]  rs, gs, bs;

   xdiv_type              xd_ff [0:NXS];
   xdiv_type              xd_in;
   logic signed [XW-1:0]  sum_w, xmag, ymag, smag;

   logic signed [CW-1:0]  xc_ff, yc_ff;
   side_type              xc_side_ff, xc_side_in;
   logic [CW:0]           xc_res, yc_res;

   ndiv_type              nd_ff [0:NNS];
   ndiv_type              nd_in;
   logic signed [NW-1:0]  num_w, den_w, nmag, dmag;

   logic signed [NCW-1:0] nr_n_ff;
   side_type              nr_side_ff, nr_side_in;
   logic [NCW:0]          nr_res;

   mul_type               mq_ff [0:2];
   mul_type               h_in;
   p0_type                p0_ff [0:1];
   p1_type                p1_ff [0:1];
   p2_type                p2_ff [0:1];

   rgbc_rsp_type          fin_ff, fin_in;
   logic signed [TW-1:0]  fin_r;

   rgbc_rsp_type          out_ff, skid_ff;
   logic                  out_vld_ff, skid_vld_ff;
   logic                  out_take;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= req_data;
      end
   end

   // xyz matrix and lux weighted sum
   always_comb begin
      rs = XW'($signed({1'b0, s1_ff.red_count}));
      gs = XW'($signed({1'b0, s1_ff.green_count}));
      bs = XW'($signed({1'b0, s1_ff.blue_count}));
      s2_x_in = XW'(M_XR) * rs + XW'(M_XG) * gs + XW'(M_XB) * bs;
      s2_y_in = XW'(M_YR) * rs + XW'(M_YG) * gs + XW'(M_YB) * bs;
      s2_z_in = XW'(M_ZR) * rs + XW'(M_ZG) * gs + XW'(M_ZB) * bs;
      s2_acc_in = LUX_WC * int'({16'd0, s1_ff.clear_count})
                + LUX_WR * int'({16'd0, s1_ff.red_count})
                + LUX_WG * int'({16'd0, s1_ff.green_count})
                + LUX_WB * int'({16'd0, s1_ff.blue_count});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x_ff   <= s2_x_in;
         s2_y_ff   <= s2_y_in;
         s2_z_ff   <= s2_z_in;
         s2_acc_ff <= s2_acc_in;
      end
   end

   // sum, lux and divider set-up; divisor is scaled by 4 so the quotient has F+2 bits
   always_comb begin
      sum_w = s2_x_ff + s2_y_ff + s2_z_ff;
      xmag  = s2_x_ff[XW-1] ? -s2_x_ff : s2_x_ff;
      ymag  = s2_y_ff[XW-1] ? -s2_y_ff : s2_y_ff;
      smag  = sum_w[XW-1] ? -sum_w : sum_w;
      xd_in.xr   = DXW'($unsigned(xmag));
      xd_in.yr   = DXW'($unsigned(ymag));
      xd_in.e    = DXW'($unsigned(smag)) << 2;
      xd_in.xq   = '0;
      xd_in.yq   = '0;
      xd_in.xneg = s2_x_ff[XW-1] ^ sum_w[XW-1];
      xd_in.yneg = s2_y_ff[XW-1] ^ sum_w[XW-1];
      xd_in.xovf = xd_in.xr >= xd_in.e;
      xd_in.yovf = xd_in.yr >= xd_in.e;
      xd_in.side.lux    = (s2_acc_ff > 0) ? s2_acc_ff[31:16] : 16'd0;
      xd_in.side.zero   = sum_w == '0;
      xd_in.side.sat    = 1'b0;
      xd_in.side.pinned = sum_w == '0;
      xd_in.side.ftemp  = 16'd0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xd_ff[0] <= xd_in;
      end
   end

   // one quotient bit per stage; the last bit is the rounding decision
   for (genvar j = 0; j < NXS; j++) begin : g_xdiv
      logic [DXW-1:0] xr2, yr2;
      logic           xb, yb;
      xdiv_type       step_in;
      assign xr2 = {xd_ff[j].xr[DXW-2:0], 1'b0};
      assign yr2 = {xd_ff[j].yr[DXW-2:0], 1'b0};
      assign xb  = xr2 >= xd_ff[j].e;
      assign yb  = yr2 >= xd_ff[j].e;
      always_comb begin
         step_in    = xd_ff[j];
         step_in.xr = xb ? xr2 - xd_ff[j].e : xr2;
         step_in.yr = yb ? yr2 - xd_ff[j].e : yr2;
         step_in.xq = {xd_ff[j].xq[QXW-2:0], xb};
         step_in.yq = {xd_ff[j].yq[QXW-2:0], yb};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            xd_ff[j+1] <= step_in;
         end
      end
   end

   // chromaticity round, sign and clamp
   assign xc_res = clamp_xy(xd_ff[NXS].xq, xd_ff[NXS].xneg, xd_ff[NXS].xovf);
   assign yc_res = clamp_xy(xd_ff[NXS].yq, xd_ff[NXS].yneg, xd_ff[NXS].yovf);

   always_comb begin
      xc_side_in     = xd_ff[NXS].side;
      xc_side_in.sat = xd_ff[NXS].side.sat | xc_res[CW] | yc_res[CW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xc_ff      <= xc_res[CW-1:0];
         yc_ff      <= yc_res[CW-1:0];
         xc_side_ff <= xc_side_in;
      end
   end

   // n divider set-up; divisor scaled by 64, zero denominator falls into overflow
   always_comb begin
      num_w = NW'(xc_ff) - NW'(CX_Q);
      den_w = NW'(CY_Q) - NW'(yc_ff);
      nmag  = num_w[NW-1] ? -num_w : num_w;
      dmag  = den_w[NW-1] ? -den_w : den_w;
      nd_in.r    = DNW'($unsigned(nmag));
      nd_in.e    = DNW'($unsigned(dmag)) << 6;
      nd_in.q    = '0;
      nd_in.neg  = num_w[NW-1] ^ den_w[NW-1];
      nd_in.ovf  = nd_in.r >= nd_in.e;
      nd_in.side = xc_side_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nd_ff[0] <= nd_in;
      end
   end

   for (genvar j = 0; j < NNS; j++) begin : g_ndiv
      logic [DNW-1:0] r2;
      logic           b;
      ndiv_type       step_in;
      assign r2 = {nd_ff[j].r[DNW-2:0], 1'b0};
      assign b  = r2 >= nd_ff[j].e;
      always_comb begin
         step_in   = nd_ff[j];
         step_in.r = b ? r2 - nd_ff[j].e : r2;
         step_in.q = {nd_ff[j].q[QNW-2:0], b};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            nd_ff[j+1] <= step_in;
         end
      end
   end

   assign nr_res = clamp_n(nd_ff[NNS].q, nd_ff[NNS].neg, nd_ff[NNS].ovf);

   always_comb begin
      nr_side_in     = nd_ff[NNS].side;
      nr_side_in.sat = nd_ff[NNS].side.sat | nr_res[NCW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nr_n_ff    <= nr_res[NCW-1:0];
         nr_side_ff <= nr_side_in;
      end
   end

   // range check on n and first horner term
   always_comb begin
      h_in.side = nr_side_ff;
      h_in.n    = nr_n_ff[NRW-1:0];
      h_in.t    = TW'(CUBIC_K1) * TW'(h_in.n) + TW'(K2_Q);
      if (!nr_side_ff.pinned) begin
         if (nr_n_ff >= NCW'(4 * ONE)) begin
            h_in.side.pinned = 1'b1;
            h_in.side.ftemp  = 16'(TEMP_MAX);
            h_in.side.sat    = 1'b1;
         end else if (nr_n_ff <= NCW'(-8 * ONE)) begin
            h_in.side.pinned = 1'b1;
            h_in.side.ftemp  = 16'd0;
            h_in.side.sat    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mq_ff[0] <= h_in;
      end
   end

   // two horner rounds: t = round(t * n / 2^F) + k, product split at bit 16
   for (genvar k = 0; k < 2; k++) begin : g_mul
      p0_type               p0_in;
      p1_type               p1_in;
      p2_type               p2_in;
      mul_type              p3_in;
      logic [PW-1:0]        prod, rnd;
      logic signed [TW-1:0] mag_t;

      always_comb begin
         p0_in.am   = mq_ff[k].t[TW-1] ? AW'($unsigned(-mq_ff[k].t))
                                        : AW'($unsigned(mq_ff[k].t));
         p0_in.nm   = mq_ff[k].n[NRW-1] ? NMW'($unsigned(-mq_ff[k].n))
                                         : NMW'($unsigned(mq_ff[k].n));
         p0_in.neg  = mq_ff[k].t[TW-1] ^ mq_ff[k].n[NRW-1];
         p0_in.n    = mq_ff[k].n;
         p0_in.side = mq_ff[k].side;
      end

      always_comb begin
         p1_in.ah   = p0_ff[k].am[AW-1:16];
         p1_in.nm   = p0_ff[k].nm;
         p1_in.pl   = PLW'(p0_ff[k].am[15:0]) * PLW'(p0_ff[k].nm);
         p1_in.neg  = p0_ff[k].neg;
         p1_in.n    = p0_ff[k].n;
         p1_in.side = p0_ff[k].side;
      end

      always_comb begin
         p2_in.ph   = PHW'(p1_ff[k].ah) * PHW'(p1_ff[k].nm);
         p2_in.pl   = p1_ff[k].pl;
         p2_in.neg  = p1_ff[k].neg;
         p2_in.n    = p1_ff[k].n;
         p2_in.side = p1_ff[k].side;
      end

      assign prod  = (PW'(p2_ff[k].ph) << 16) + PW'(p2_ff[k].pl);
      assign rnd   = prod + PW'(HALF);
      assign mag_t = TW'(rnd[PW-1:F]);

      always_comb begin
         p3_in.t    = (p2_ff[k].neg ? -mag_t : mag_t) + TW'(k == 0 ? K3_Q : K4_Q);
         p3_in.n    = p2_ff[k].n;
         p3_in.side = p2_ff[k].side;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            p0_ff[k]   <= p0_in;
            p1_ff[k]   <= p1_in;
            p2_ff[k]   <= p2_in;
            mq_ff[k+1] <= p3_in;
         end
      end
   end

   // final rounding and clamp to 16 bits
   assign fin_r = (mq_ff[2].t + TW'(HALF)) >>> F;

   always_comb begin
      fin_in.lux_estimate = mq_ff[2].side.lux;
      fin_in.sum_was_zero = mq_ff[2].side.zero;
      fin_in.temp_saturated = mq_ff[2].side.sat;
      if (mq_ff[2].side.pinned) begin
         fin_in.colour_temp_kelvin = mq_ff[2].side.ftemp;
      end else if (mq_ff[2].t < 0) begin
         fin_in.colour_temp_kelvin = 16'd0;
         if (mq_ff[2].t <= TW'(-HALF)) begin
            fin_in.temp_saturated = 1'b1;
         end
      end else if (fin_r > TW'(TEMP_MAX)) begin
         fin_in.colour_temp_kelvin = 16'(TEMP_MAX);
         fin_in.temp_saturated     = 1'b1;
      end else begin
         fin_in.colour_temp_kelvin = fin_r[15:0];
      end
      // zero sum never reports saturation
      if (mq_ff[2].side.zero) begin
         fin_in.temp_saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   // output register plus skid stage
   assign out_take = out_vld_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || out_take) begin
         out_vld_ff <= vld_ff[DEPTH-1];
      end else if (vld_ff[DEPTH-1]) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_vld_ff || out_take) begin
         out_ff <= fin_ff;
      end else begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !out_take |=> skid_vld_ff && $stable(skid_ff))
      else $error("skid item lost before the output drained");

   a_tail_frozen: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-1] && !adv |=> vld_ff[DEPTH-1] && $stable(fin_ff))
      else $error("pipeline tail moved while frozen");

   a_zero_sum_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sum_was_zero |->
         rsp_data.colour_temp_kelvin == 16'd0 && !rsp_data.temp_saturated)
      else $error("zero xyz sum with nonzero temperature or saturation");
`endif

endmodule

`default_nettype wire
